FILE: design/lamb_pkg.sv
`timescale 1ns / 1ps

package lamb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int VW        = 36;
    localparam int MW        = VW;
    localparam int LZW       = $clog2(MW);
    localparam int NORM_TOP  = 29;
    localparam int PW        = NORM_TOP + 1;
    localparam int SQW       = 2 * PW + 2;
    localparam int RW        = PW + 1;
    localparam int SQ_STEPS  = RW;
    localparam int REMW      = RW + 3;
    localparam int DRW       = RW + 1;
    localparam int QW        = FRAC_BITS + 1;
    localparam int UW        = FRAC_BITS + 2;
    localparam int NW        = PW + FRAC_BITS + 1;

    localparam logic [DW-1:0] ONE_FIX = DW'(1) << FRAC_BITS;

    typedef logic [2:0][VW-1:0] t_vec;
    typedef logic [2:0][UW-1:0] t_unit;
    typedef logic [2:0][DW-1:0] t_word3;

    typedef struct packed {
        t_word3 pos;
        t_word3 up;
        t_unit  fwd;
        logic   degen;
    } t_side;

    typedef enum logic [1:0] {
        ROW_RIGHT = 2'd0,
        ROW_UP    = 2'd1,
        ROW_FWD   = 2'd2,
        ROW_POS   = 2'd3
    } t_row;

    // Divides by 2^FRAC_BITS, rounding the magnitude to nearest with ties away from zero.
    function automatic logic signed [63:0] round_frac(input logic signed [63:0] v);
        logic signed [63:0] h;
        h = (64'sd1 <<< (FRAC_BITS - 1)) - 64'(v[63]);
        return (v + h) >>> FRAC_BITS;
    endfunction

endpackage

FILE: design/look_at_matrix_builder_core.sv
`timescale 1ns / 1ps

// Builds a look-at matrix from a camera position, a target point and an up direction, all signed
// Q16.16, and sends it out as four rows: right, up, forward and position, the last one flagged.
// The computation is a fully pipelined datapath (two vector normalisations, each with a
// one-bit-per-stage square root and divider), so a new request may enter in any cycle in which
// o_stall is low. The output side sends one row per cycle while i_stall is low, so the sustained
// request rate is set by the four-row output sequencer. A stall on the output holds the whole
// pipeline without loss once a finished result waits for the output register.

module look_at_matrix_builder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_up_x,
    input  logic signed [31:0] i_up_y,
    input  logic signed [31:0] i_up_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_elem_0,
    output logic signed [31:0] o_elem_1,
    output logic signed [31:0] o_elem_2,
    output logic signed [31:0] o_elem_3,
    output logic               o_last_row,
    output logic               o_degenerate
);

    localparam int PRW  = lamb_pkg::DW + lamb_pkg::UW;
    localparam int DOTW = PRW + 2;
    localparam int KW   = 34;
    localparam int FKW  = lamb_pkg::UW + KW;
    localparam int CPW  = 2 * lamb_pkg::UW;

    typedef struct packed {
        logic [2:0][PRW-1:0] prod;
        lamb_pkg::t_side     side;
    } t_s1;

    typedef struct packed {
        logic [DOTW-1:0] dot;
        lamb_pkg::t_side side;
    } t_s2;

    typedef struct packed {
        logic [KW-1:0]   k;
        lamb_pkg::t_side side;
    } t_s3;

    typedef struct packed {
        logic [2:0][FKW-1:0] fk;
        lamb_pkg::t_side     side;
    } t_s4;

    typedef struct packed {
        lamb_pkg::t_vec  u;
        lamb_pkg::t_side side;
    } t_s5;

    typedef struct packed {
        logic [2:0][CPW-1:0] pa;
        logic [2:0][CPW-1:0] pb;
        lamb_pkg::t_unit     upn;
        lamb_pkg::t_side     side;
    } t_s6;

    typedef struct packed {
        lamb_pkg::t_word3 rt;
        lamb_pkg::t_unit  upn;
        lamb_pkg::t_side  side;
    } t_s7;

    logic            w_adv;
    logic            w_take;
    logic            r_v0;
    lamb_pkg::t_vec  r_d0, n_d0;
    lamb_pkg::t_side r_side0, n_side0;
    logic            w_n1_v, w_n1_z;
    lamb_pkg::t_unit w_n1_u;
    lamb_pkg::t_side w_n1_s;
    logic [4:0]      r_vmid;
    t_s1             r_s1, n_s1;
    t_s2             r_s2, n_s2;
    t_s3             r_s3, n_s3;
    t_s4             r_s4, n_s4;
    t_s5             r_s5, n_s5;
    logic            w_n2_v, w_n2_z;
    lamb_pkg::t_unit w_n2_u;
    lamb_pkg::t_side w_n2_s;
    logic [1:0]      r_vpost;
    t_s6             r_s6, n_s6;
    t_s7             r_s7, n_s7;
    t_s7             r_out;
    logic            r_ov;
    lamb_pkg::t_row  r_row, n_row;

    assign w_take  = r_vpost[1] && (!r_ov || (r_row == lamb_pkg::ROW_POS && !i_stall));
    assign w_adv   = !r_vpost[1] || w_take;
    assign o_stall = !w_adv;

    always_comb begin
        n_side0.pos = {i_pos_z, i_pos_y, i_pos_x};
        n_side0.up  = {i_up_z, i_up_y, i_up_x};
        n_side0.fwd = '0;
        n_side0.degen = 1'b0;
        n_d0[0] = lamb_pkg::VW'($signed(i_target_x)) - lamb_pkg::VW'($signed(i_pos_x));
        n_d0[1] = lamb_pkg::VW'($signed(i_target_y)) - lamb_pkg::VW'($signed(i_pos_y));
        n_d0[2] = lamb_pkg::VW'($signed(i_target_z)) - lamb_pkg::VW'($signed(i_pos_z));
    end

    lamb_norm u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_v0),
        .i_vec   (r_d0),
        .i_side  (r_side0),
        .o_valid (w_n1_v),
        .o_unit  (w_n1_u),
        .o_zero  (w_n1_z),
        .o_side  (w_n1_s)
    );

    always_comb begin
        n_s1.side       = w_n1_s;
        n_s1.side.fwd   = w_n1_u;
        n_s1.side.degen = w_n1_z;
        for (int i = 0; i < 3; i++) begin
            n_s1.prod[i] = PRW'($signed(w_n1_s.up[i])) * PRW'($signed(w_n1_u[i]));
        end
        n_s2.side = r_s1.side;
        n_s2.dot  = DOTW'($signed(r_s1.prod[0])) + DOTW'($signed(r_s1.prod[1]))
                  + DOTW'($signed(r_s1.prod[2]));
        n_s3.side = r_s2.side;
        n_s3.k    = KW'(lamb_pkg::round_frac(64'($signed(r_s2.dot))));
        n_s4.side = r_s3.side;
        for (int i = 0; i < 3; i++) begin
            n_s4.fk[i] = FKW'($signed(r_s3.side.fwd[i])) * FKW'($signed(r_s3.k));
        end
        n_s5.side = r_s4.side;
        for (int i = 0; i < 3; i++) begin
            n_s5.u[i] = lamb_pkg::VW'($signed(r_s4.side.up[i]))
                      - lamb_pkg::VW'(lamb_pkg::round_frac(64'($signed(r_s4.fk[i]))));
        end
    end

    lamb_norm u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_vmid[4]),
        .i_vec   (r_s5.u),
        .i_side  (r_s5.side),
        .o_valid (w_n2_v),
        .o_unit  (w_n2_u),
        .o_zero  (w_n2_z),
        .o_side  (w_n2_s)
    );

    always_comb begin
        n_s6.side       = w_n2_s;
        n_s6.side.degen = w_n2_s.degen | w_n2_z;
        n_s6.upn        = w_n2_u;
        n_s6.pa[0] = CPW'($signed(w_n2_u[1])) * CPW'($signed(w_n2_s.fwd[2]));
        n_s6.pb[0] = CPW'($signed(w_n2_u[2])) * CPW'($signed(w_n2_s.fwd[1]));
        n_s6.pa[1] = CPW'($signed(w_n2_u[2])) * CPW'($signed(w_n2_s.fwd[0]));
        n_s6.pb[1] = CPW'($signed(w_n2_u[0])) * CPW'($signed(w_n2_s.fwd[2]));
        n_s6.pa[2] = CPW'($signed(w_n2_u[0])) * CPW'($signed(w_n2_s.fwd[1]));
        n_s6.pb[2] = CPW'($signed(w_n2_u[1])) * CPW'($signed(w_n2_s.fwd[0]));
        n_s7.side = r_s6.side;
        n_s7.upn  = r_s6.upn;
        for (int i = 0; i < 3; i++) begin
            n_s7.rt[i] = lamb_pkg::DW'(lamb_pkg::round_frac(
                64'($signed(r_s6.pa[i])) - 64'($signed(r_s6.pb[i]))));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_vmid  <= '0;
            r_vpost <= '0;
        end else if (w_adv) begin
            r_v0    <= i_valid;
            r_vmid  <= {r_vmid[3:0], w_n1_v};
            r_vpost <= {r_vpost[0], w_n2_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d0    <= n_d0;
            r_side0 <= n_side0;
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_s3    <= n_s3;
            r_s4    <= n_s4;
            r_s5    <= n_s5;
            r_s6    <= n_s6;
            r_s7    <= n_s7;
        end
    end

    always_comb begin
        unique case (r_row)
            lamb_pkg::ROW_RIGHT: n_row = lamb_pkg::ROW_UP;
            lamb_pkg::ROW_UP:    n_row = lamb_pkg::ROW_FWD;
            lamb_pkg::ROW_FWD:   n_row = lamb_pkg::ROW_POS;
            lamb_pkg::ROW_POS:   n_row = lamb_pkg::ROW_RIGHT;
            default:             n_row = lamb_pkg::ROW_RIGHT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_row <= lamb_pkg::ROW_RIGHT;
        end else if (w_take) begin
            r_ov  <= 1'b1;
            r_row <= lamb_pkg::ROW_RIGHT;
        end else if (r_ov && !i_stall) begin
            r_row <= n_row;
            if (r_row == lamb_pkg::ROW_POS) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= r_s7;
        end
    end

    always_comb begin
        o_valid      = r_ov;
        o_row_index  = r_row;
        o_last_row   = (r_row == lamb_pkg::ROW_POS);
        o_degenerate = r_out.side.degen;
        o_elem_3     = '0;
        unique case (r_row)
            lamb_pkg::ROW_RIGHT: begin
                o_elem_0 = r_out.rt[0];
                o_elem_1 = r_out.rt[1];
                o_elem_2 = r_out.rt[2];
            end
            lamb_pkg::ROW_UP: begin
                o_elem_0 = lamb_pkg::DW'($signed(r_out.upn[0]));
                o_elem_1 = lamb_pkg::DW'($signed(r_out.upn[1]));
                o_elem_2 = lamb_pkg::DW'($signed(r_out.upn[2]));
            end
            lamb_pkg::ROW_FWD: begin
                o_elem_0 = lamb_pkg::DW'($signed(r_out.side.fwd[0]));
                o_elem_1 = lamb_pkg::DW'($signed(r_out.side.fwd[1]));
                o_elem_2 = lamb_pkg::DW'($signed(r_out.side.fwd[2]));
            end
            lamb_pkg::ROW_POS: begin
                o_elem_0 = r_out.side.pos[0];
                o_elem_1 = r_out.side.pos[1];
                o_elem_2 = r_out.side.pos[2];
                o_elem_3 = lamb_pkg::ONE_FIX;
            end
            default: begin
                o_elem_0 = '0;
                o_elem_1 = '0;
                o_elem_2 = '0;
            end
        endcase
    end

endmodule

FILE: design/lamb_norm.sv
`timescale 1ns / 1ps

module lamb_norm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  lamb_pkg::t_vec   i_vec,
    input  lamb_pkg::t_side  i_side,
    output logic             o_valid,
    output lamb_pkg::t_unit  o_unit,
    output logic             o_zero,
    output lamb_pkg::t_side  o_side
);

    localparam int NST = 4 + (lamb_pkg::SQ_STEPS + 1) + (lamb_pkg::QW + 1) + 1;

    typedef struct packed {
        logic [2:0][lamb_pkg::MW-1:0] mag;
        logic [2:0]                   neg;
        logic [lamb_pkg::MW-1:0]      mx;
        lamb_pkg::t_side              side;
    } t_sa;

    typedef struct packed {
        logic [2:0][lamb_pkg::MW-1:0] mag;
        logic [2:0]                   neg;
        logic [lamb_pkg::LZW-1:0]     msb;
        logic                         zero;
        lamb_pkg::t_side              side;
    } t_sb;

    typedef struct packed {
        logic [2:0][lamb_pkg::PW-1:0] sm;
        logic [2:0]                   neg;
        logic                         zero;
        lamb_pkg::t_side              side;
    } t_sc;

    typedef struct packed {
        logic [2:0][2*lamb_pkg::PW-1:0] sq;
        logic [2:0][lamb_pkg::PW-1:0]   sm;
        logic [2:0]                     neg;
        logic                           zero;
        lamb_pkg::t_side                side;
    } t_sd;

    typedef struct packed {
        logic [lamb_pkg::REMW-1:0]    rem;
        logic [lamb_pkg::RW-1:0]      root;
        logic [lamb_pkg::SQW-1:0]     s;
        logic [2:0][lamb_pkg::PW-1:0] sm;
        logic [2:0]                   neg;
        logic                         zero;
        lamb_pkg::t_side              side;
    } t_sq;

    typedef struct packed {
        logic [2:0][lamb_pkg::DRW-1:0]   rem;
        logic [2:0][lamb_pkg::FRAC_BITS:0] nlo;
        logic [lamb_pkg::RW-1:0]         len;
        logic [2:0][lamb_pkg::QW-1:0]    q;
        logic [2:0]                      neg;
        logic                            zero;
        lamb_pkg::t_side                 side;
    } t_dv;

    logic [NST-1:0] r_vld;
    t_sa r_sa, n_sa;
    t_sb r_sb, n_sb;
    t_sc r_sc, n_sc;
    t_sd r_sd, n_sd;
    t_sq r_sq [0:lamb_pkg::SQ_STEPS];
    t_sq n_sq [0:lamb_pkg::SQ_STEPS];
    t_dv r_dv [0:lamb_pkg::QW];
    t_dv n_dv [0:lamb_pkg::QW];
    lamb_pkg::t_unit r_unit, n_unit;
    logic            r_zero;
    lamb_pkg::t_side r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_comb begin
        n_sa.mx   = '0;
        n_sa.side = i_side;
        for (int i = 0; i < 3; i++) begin
            n_sa.neg[i] = i_vec[i][lamb_pkg::VW-1];
            n_sa.mag[i] = n_sa.neg[i] ? lamb_pkg::MW'(-$signed(i_vec[i])) : i_vec[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (n_sa.mag[i] > n_sa.mx) begin
                n_sa.mx = n_sa.mag[i];
            end
        end
    end

    always_comb begin
        n_sb.mag  = r_sa.mag;
        n_sb.neg  = r_sa.neg;
        n_sb.side = r_sa.side;
        n_sb.zero = (r_sa.mx == '0);
        n_sb.msb  = '0;
        for (int b = 0; b < lamb_pkg::MW; b++) begin
            if (r_sa.mx[b]) begin
                n_sb.msb = lamb_pkg::LZW'(b);
            end
        end
    end

    always_comb begin
        n_sc.neg  = r_sb.neg;
        n_sc.zero = r_sb.zero;
        n_sc.side = r_sb.side;
        for (int i = 0; i < 3; i++) begin
            if (r_sb.msb >= lamb_pkg::LZW'(lamb_pkg::NORM_TOP)) begin
                n_sc.sm[i] = lamb_pkg::PW'(r_sb.mag[i] >>
                                           (r_sb.msb - lamb_pkg::LZW'(lamb_pkg::NORM_TOP)));
            end else begin
                n_sc.sm[i] = lamb_pkg::PW'(r_sb.mag[i] <<
                                           (lamb_pkg::LZW'(lamb_pkg::NORM_TOP) - r_sb.msb));
            end
        end
    end

    always_comb begin
        n_sd.sm   = r_sc.sm;
        n_sd.neg  = r_sc.neg;
        n_sd.zero = r_sc.zero;
        n_sd.side = r_sc.side;
        for (int i = 0; i < 3; i++) begin
            n_sd.sq[i] = (2*lamb_pkg::PW)'(r_sc.sm[i]) * (2*lamb_pkg::PW)'(r_sc.sm[i]);
        end
    end

    always_comb begin
        logic [lamb_pkg::REMW-1:0] rs;
        logic [lamb_pkg::REMW-1:0] tr;
        n_sq[0].rem  = '0;
        n_sq[0].root = '0;
        n_sq[0].s    = lamb_pkg::SQW'(r_sd.sq[0]) + lamb_pkg::SQW'(r_sd.sq[1])
                     + lamb_pkg::SQW'(r_sd.sq[2]);
        n_sq[0].sm   = r_sd.sm;
        n_sq[0].neg  = r_sd.neg;
        n_sq[0].zero = r_sd.zero;
        n_sq[0].side = r_sd.side;
        for (int k = 0; k < lamb_pkg::SQ_STEPS; k++) begin
            n_sq[k+1] = r_sq[k];
            rs = {r_sq[k].rem[lamb_pkg::REMW-3:0],
                  r_sq[k].s[2*(lamb_pkg::SQ_STEPS-1-k) +: 2]};
            tr = lamb_pkg::REMW'({r_sq[k].root, 2'b01});
            if (rs >= tr) begin
                n_sq[k+1].rem  = rs - tr;
                n_sq[k+1].root = {r_sq[k].root[lamb_pkg::RW-2:0], 1'b1};
            end else begin
                n_sq[k+1].rem  = rs;
                n_sq[k+1].root = {r_sq[k].root[lamb_pkg::RW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [lamb_pkg::NW-1:0]  num;
        logic [lamb_pkg::DRW-1:0] rs;
        n_dv[0].len  = r_sq[lamb_pkg::SQ_STEPS].root;
        n_dv[0].q    = '0;
        n_dv[0].neg  = r_sq[lamb_pkg::SQ_STEPS].neg;
        n_dv[0].zero = r_sq[lamb_pkg::SQ_STEPS].zero;
        n_dv[0].side = r_sq[lamb_pkg::SQ_STEPS].side;
        for (int i = 0; i < 3; i++) begin
            num = (lamb_pkg::NW'(r_sq[lamb_pkg::SQ_STEPS].sm[i]) << lamb_pkg::FRAC_BITS)
                + lamb_pkg::NW'(r_sq[lamb_pkg::SQ_STEPS].root >> 1);
            n_dv[0].rem[i] = lamb_pkg::DRW'(num[lamb_pkg::NW-1:lamb_pkg::FRAC_BITS+1]);
            n_dv[0].nlo[i] = num[lamb_pkg::FRAC_BITS:0];
        end
        for (int k = 0; k < lamb_pkg::QW; k++) begin
            n_dv[k+1] = r_dv[k];
            for (int i = 0; i < 3; i++) begin
                rs = {r_dv[k].rem[i][lamb_pkg::DRW-2:0], r_dv[k].nlo[i][lamb_pkg::QW-1-k]};
                if (rs >= lamb_pkg::DRW'(r_dv[k].len)) begin
                    n_dv[k+1].rem[i] = rs - lamb_pkg::DRW'(r_dv[k].len);
                    n_dv[k+1].q[i]   = {r_dv[k].q[i][lamb_pkg::QW-2:0], 1'b1};
                end else begin
                    n_dv[k+1].rem[i] = rs;
                    n_dv[k+1].q[i]   = {r_dv[k].q[i][lamb_pkg::QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv[lamb_pkg::QW].zero) begin
                n_unit[i] = '0;
            end else if (r_dv[lamb_pkg::QW].neg[i]) begin
                n_unit[i] = lamb_pkg::UW'(-$signed({1'b0, r_dv[lamb_pkg::QW].q[i]}));
            end else begin
                n_unit[i] = lamb_pkg::UW'(r_dv[lamb_pkg::QW].q[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sa <= n_sa;
            r_sb <= n_sb;
            r_sc <= n_sc;
            r_sd <= n_sd;
            for (int k = 0; k <= lamb_pkg::SQ_STEPS; k++) begin
                r_sq[k] <= n_sq[k];
            end
            for (int k = 0; k <= lamb_pkg::QW; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_unit <= n_unit;
            r_zero <= r_dv[lamb_pkg::QW].zero;
            r_side <= r_dv[lamb_pkg::QW].side;
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_unit  = r_unit;
    assign o_zero  = r_zero;
    assign o_side  = r_side;

endmodule

FILE: design/lamb_checker.sv
`timescale 1ns / 1ps

module lamb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_row_index,
    input logic signed [31:0] o_elem_0,
    input logic signed [31:0] o_elem_3,
    input logic               o_last_row,
    input logic               o_degenerate
);

    // A held result stays valid and keeps its row and first element.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_row_index) && $stable(o_elem_0))
        else $error("stalled result changed");

    // The rows of one matrix follow each other without a gap.
    a_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_row_index != lamb_pkg::ROW_POS
        |=> o_valid && o_row_index == $past(o_row_index) + 2'd1)
        else $error("row sequence broken");

    // The degenerate flag is the same on all rows of one matrix.
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_row_index != lamb_pkg::ROW_POS |=> $stable(o_degenerate))
        else $error("degenerate flag changed within a matrix");

    // Only the position row carries w = 1 and the last-row flag.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == lamb_pkg::ROW_POS))
                    && (o_elem_3 == (o_last_row ? $signed(lamb_pkg::ONE_FIX) : 32'sd0)))
        else $error("last row or w column wrong");

endmodule

bind look_at_matrix_builder_core lamb_checker u_lamb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_row_index  (o_row_index),
    .o_elem_0     (o_elem_0),
    .o_elem_3     (o_elem_3),
    .o_last_row   (o_last_row),
    .o_degenerate (o_degenerate)
);

FILE: test/tb_look_at_matrix_builder_core.sv
`timescale 1ns / 1ps

module tb_look_at_matrix_builder_core;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] e0;
        logic [31:0] e1;
        logic [31:0] e2;
        logic [31:0] e3;
        logic        last;
        logic        degen;
    } t_row_exp;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_target_x, i_target_y, i_target_z;
    logic signed [31:0] i_up_x, i_up_y, i_up_z;
    logic o_valid;
    logic i_stall;
    logic [1:0] o_row_index;
    logic signed [31:0] o_elem_0, o_elem_1, o_elem_2, o_elem_3;
    logic o_last_row;
    logic o_degenerate;

    t_row_exp expected_rows[$];
    int errors;
    int rows_checked;
    int requests_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    look_at_matrix_builder_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_target_x(i_target_x), .i_target_y(i_target_y), .i_target_z(i_target_z),
        .i_up_x(i_up_x), .i_up_y(i_up_y), .i_up_z(i_up_z),
        .o_valid(o_valid), .i_stall(i_stall), .o_row_index(o_row_index),
        .o_elem_0(o_elem_0), .o_elem_1(o_elem_1), .o_elem_2(o_elem_2),
        .o_elem_3(o_elem_3), .o_last_row(o_last_row), .o_degenerate(o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint mag_of(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint fix_round(longint v);
        longint m;
        m = (mag_of(v) + (longint'(1) << (lamb_pkg::FRAC_BITS - 1))) >>> lamb_pkg::FRAC_BITS;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // Normalises v; returns 1 when the vector has zero length.
    function automatic bit normalise(input longint v[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned s;
        longint unsigned len;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag_of(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return 1'b1;
        end
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            o[i] = longint'(((m[i] << lamb_pkg::FRAC_BITS) + (len >> 1)) / len);
            if (v[i] < 0) o[i] = -o[i];
        end
        return 1'b0;
    endfunction

    task automatic predict_matrix(input logic signed [31:0] p[3],
                                  input logic signed [31:0] t[3],
                                  input logic signed [31:0] u[3]);
        longint d[3], fwd[3], upo[3], upn[3], rt[3];
        longint k;
        bit degen;
        t_row_exp r;
        for (int i = 0; i < 3; i++) d[i] = longint'(t[i]) - longint'(p[i]);
        degen = normalise(d, fwd);
        k = fix_round(longint'(u[0]) * fwd[0] + longint'(u[1]) * fwd[1]
                      + longint'(u[2]) * fwd[2]);
        for (int i = 0; i < 3; i++) upo[i] = longint'(u[i]) - fix_round(fwd[i] * k);
        if (normalise(upo, upn)) degen = 1'b1;
        rt[0] = fix_round(upn[1] * fwd[2] - upn[2] * fwd[1]);
        rt[1] = fix_round(upn[2] * fwd[0] - upn[0] * fwd[2]);
        rt[2] = fix_round(upn[0] * fwd[1] - upn[1] * fwd[0]);
        r.degen = degen;
        r.e3 = '0;
        r.last = 1'b0;
        r.row = lamb_pkg::ROW_RIGHT;
        r.e0 = rt[0][31:0]; r.e1 = rt[1][31:0]; r.e2 = rt[2][31:0];
        expected_rows.push_back(r);
        r.row = lamb_pkg::ROW_UP;
        r.e0 = upn[0][31:0]; r.e1 = upn[1][31:0]; r.e2 = upn[2][31:0];
        expected_rows.push_back(r);
        r.row = lamb_pkg::ROW_FWD;
        r.e0 = fwd[0][31:0]; r.e1 = fwd[1][31:0]; r.e2 = fwd[2][31:0];
        expected_rows.push_back(r);
        r.row = lamb_pkg::ROW_POS;
        r.e0 = p[0]; r.e1 = p[1]; r.e2 = p[2];
        r.e3 = lamb_pkg::ONE_FIX;
        r.last = 1'b1;
        expected_rows.push_back(r);
    endtask

    task automatic send_request(input logic signed [31:0] p[3],
                                input logic signed [31:0] t[3],
                                input logic signed [31:0] u[3]);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= p[0]; i_pos_y <= p[1]; i_pos_z <= p[2];
        i_target_x <= t[0]; i_target_y <= t[1]; i_target_z <= t[2];
        i_up_x <= u[0]; i_up_y <= u[1]; i_up_z <= u[2];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_matrix(p, t, u);
        requests_sent++;
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(4))
            0: return $urandom_range(8) << 14;
            1: return -($urandom_range(8) << 14);
            2: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int n);
        logic signed [31:0] p[3], t[3], u[3];
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < 3; i++) begin
                p[i] = rand_word();
                t[i] = ($urandom_range(9) == 0) ? p[i] : rand_word();
                u[i] = rand_word();
            end
            send_request(p, t, u);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic signed [31:0] p[3], t[3], u[3];
        logic signed [31:0] ext[4];
        ext[0] = 32'sh7FFF_FFFF; ext[1] = 32'sh8000_0000; ext[2] = 0; ext[3] = 32'sh0001_0000;
        // Plain camera looking along -z with y up.
        p = '{0, 0, 32'sh0005_0000}; t = '{0, 0, 0}; u = '{0, 32'sh0001_0000, 0};
        send_request(p, t, u);
        // Target equal to position gives a zero forward vector.
        p = '{32'sh0001_0000, 2, 3}; t = p; u = '{0, 32'sh0001_0000, 0};
        send_request(p, t, u);
        // Up parallel to forward collapses after Gram-Schmidt.
        p = '{0, 0, 0}; t = '{0, 32'sh0003_0000, 0}; u = '{0, 32'sh0001_0000, 0};
        send_request(p, t, u);
        // Zero up vector.
        u = '{0, 0, 0};
        send_request(p, t, u);
        // Both forward and up zero.
        t = p;
        send_request(p, t, u);
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                p = '{ext[a], ext[b], ext[(a + b) % 4]};
                t = '{ext[b], ext[a], ext[(a + 1) % 4]};
                u = '{ext[(b + 1) % 4], ext[a], ext[b]};
                send_request(p, t, u);
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles <= 400;
        send_random(20);
        wait_drained();
    endtask

    initial begin
        errors = 0; rows_checked = 0; requests_sent = 0; hold_cycles = 0;
        send_idle_pct = 28; recv_idle_pct = 88;
        i_rst_n <= 1'b0; i_valid <= 1'b0;
        i_pos_x <= '0; i_pos_y <= '0; i_pos_z <= '0;
        i_target_x <= '0; i_target_y <= '0; i_target_z <= '0;
        i_up_x <= '0; i_up_y <= '0; i_up_z <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_random(30);
        wait_drained();
        send_idle_pct = 88; recv_idle_pct = 28;
        send_random(30);
        send_idle_pct = 0; recv_idle_pct = 0;
        send_random(30);
        test_backpressure();
        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d requests, checked %0d matrix rows, with degenerate vectors,",
                 requests_sent, rows_checked);
        $display("extreme coordinates, random idling and a long output hold-off.");
        if (errors == 0 && expected_rows.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_row_exp e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rows.size() == 0) begin
                $error("unexpected row %0d", o_row_index);
                errors++;
            end else begin
                e = expected_rows.pop_front();
                rows_checked++;
                if (o_row_index !== e.row) begin
                    $error("row_index exp %0d got %0d", e.row, o_row_index); errors++;
                end
                if (o_elem_0 !== e.e0) begin
                    $error("elem_0 exp %h got %h", e.e0, o_elem_0); errors++;
                end
                if (o_elem_1 !== e.e1) begin
                    $error("elem_1 exp %h got %h", e.e1, o_elem_1); errors++;
                end
                if (o_elem_2 !== e.e2) begin
                    $error("elem_2 exp %h got %h", e.e2, o_elem_2); errors++;
                end
                if (o_elem_3 !== e.e3) begin
                    $error("elem_3 exp %h got %h", e.e3, o_elem_3); errors++;
                end
                if (o_last_row !== e.last) begin
                    $error("last_row exp %0d got %0d", e.last, o_last_row); errors++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate exp %0d got %0d", e.degen, o_degenerate); errors++;
                end
            end
        end
    end

endmodule
